// ===== src/emb_pkg.sv =====
// Shared types and constants of the 3x3 emboss filter.
// Used by emb_col_cell, emb_filter and the top level; depends on nothing else.
`default_nettype none

package emb_pkg;

   // Frame geometry.
   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MIN_DIM           = 3;
   localparam int PIX_MAX           = 255;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd1024;

   // Result coordinate widths.
   localparam int ROW_W    = 16;
   localparam int OUT_COL_W = 10;

   // Emboss kernel, indexed [row][column] of the window.
   localparam int KERNEL [3][3] = '{'{-2, -1, 0}, '{-1, 1, 1}, '{0, 1, 2}};

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // One window column, element 0 is the top row.
   typedef pixel_type [2:0] col_type;
   // Whole window, element 0 is the leftmost column.
   typedef col_type [2:0] win_type;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]     out_row;
      logic [OUT_COL_W-1:0] out_col;
      logic [7:0]           red_out;
      logic [7:0]           green_out;
      logic [7:0]           blue_out;
      logic                 last_of_run;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/emb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Holds the line stores of the emboss filter; no dependencies.
`default_nettype none

module emb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/emb_col_cell.sv =====
// One column cell of the emboss window: holds three pixels and hands them on.
// Depends on emb_pkg.
`default_nettype none

module emb_col_cell (
   input  wire                  clock,
   input  wire                  shift,
   input  emb_pkg::col_type     col_in,
   output emb_pkg::col_type     col_out
);

   emb_pkg::col_type col_ff;
   emb_pkg::col_type col_in_w;

   assign col_in_w = shift ? col_in : col_ff;

   always_ff @(posedge clock) begin
      col_ff <= col_in_w;
   end

   assign col_out = col_ff;

endmodule

`default_nettype wire

// ===== src/emb_filter.sv =====
// Emboss kernel over a 3x3 window, one lane per colour channel, clamped to 0..255.
// Depends on emb_pkg.
`default_nettype none

module emb_filter (
   input  emb_pkg::win_type    win,
   output emb_pkg::pixel_type  pix_out
);

   logic [2:0][2:0][7:0] red_taps;
   logic [2:0][2:0][7:0] green_taps;
   logic [2:0][2:0][7:0] blue_taps;

   // The sum lies in -1020..1275, so twelve signed bits hold it.
   function automatic logic [7:0] emboss_chan(input logic [2:0][2:0][7:0] taps);
      logic signed [11:0] acc;
      logic [7:0]         res;
      acc = '0;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            acc = acc + 12'($signed({4'b0000, taps[k][i]}) * emb_pkg::KERNEL[i][k]);
         end
      end
      if (acc > 12'sd255) begin
         res = 8'(emb_pkg::PIX_MAX);
      end else if (acc < 12'sd0) begin
         res = '0;
      end else begin
         res = acc[7:0];
      end
      return res;
   endfunction

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            red_taps[k][i]   = win[k][i].red;
            green_taps[k][i] = win[k][i].green;
            blue_taps[k][i]  = win[k][i].blue;
         end
      end
   end

   assign pix_out.red   = emboss_chan(red_taps);
   assign pix_out.green = emboss_chan(green_taps);
   assign pix_out.blue  = emboss_chan(blue_taps);

endmodule

`default_nettype wire

// ===== src/emboss_3x3_rgb_filter.sv =====
// 3x3 emboss filter over an RGB raster stream; top level.
// A result passes the pixel stage and output stage registers before it is offered.
// Throughput: one pixel per cycle unless the output stalls; two results fill both slots.
// The line stores are read at transfer and written when the pixel leaves the pixel stage.
// Reset clears the position counters and pipeline state and sets both frame registers to 1024;
// the line stores and window are not cleared. Depends on emb_pkg, emb_ram, emb_col_cell,
// emb_filter.
`default_nettype none

module emboss_3x3_rgb_filter #(
   parameter int MAX_WIDTH = emb_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  emb_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output emb_pkg::rsp_type                   rsp_data,
   input  wire                                csr_we,
   input  wire [emb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [emb_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = emb_pkg::ROW_W;

   // Configuration registers and position counters.
   logic [emb_pkg::WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [emb_pkg::HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic [WW-1:0] eff_w;
   logic [RW-1:0] eff_h;

   // Pixel stage: holds the transferred pixel while the line stores are read.
   logic              s1_valid_ff, s1_valid_in;
   emb_pkg::pixel_type s1_px_ff, s1_px_in;
   logic [RW-1:0]     s1_row_ff, s1_row_in;
   logic [CW-1:0]     s1_col_ff, s1_col_in;
   logic              s1_filt_ff, s1_filt_in;
   logic              s1_border_ff, s1_border_in;

   // Output stage: up to two results waiting for transfer.
   logic [1:0]        cnt_ff, cnt_in;
   emb_pkg::rsp_type  slot0_ff, slot0_in;
   emb_pkg::rsp_type  slot1_ff, slot1_in;

   logic              accept;
   logic              adv;
   logic              out_free;
   logic              pop;
   logic [1:0]        s1_n;
   logic              cur_filt;
   logic              cur_border;

   emb_pkg::pixel_type req_px;
   emb_pkg::pixel_type top_px;
   emb_pkg::pixel_type mid_px;
   emb_pkg::pixel_type filt_px;
   emb_pkg::col_type   new_col;
   emb_pkg::col_type   cell0_col;
   emb_pkg::col_type   cell1_col;
   emb_pkg::win_type   win;
   emb_pkg::rsp_type   res_filt;
   emb_pkg::rsp_type   res_border;

   assign req_px.red   = req_data.red_in;
   assign req_px.green = req_data.green_in;
   assign req_px.blue  = req_data.blue_in;

   // Effective frame size after clamping to the supported range.
   always_comb begin
      if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else if (32'(width_ff) < 32'(emb_pkg::MIN_DIM)) begin
         eff_w = WW'(emb_pkg::MIN_DIM);
      end else begin
         eff_w = WW'(width_ff);
      end
      if (32'(height_ff) < 32'(emb_pkg::MIN_DIM)) begin
         eff_h = RW'(emb_pkg::MIN_DIM);
      end else begin
         eff_h = height_ff;
      end
   end

   assign cur_filt   = (row_ff >= RW'(2)) && (col_ff >= CW'(2));
   assign cur_border = (row_ff == '0) || (row_ff == eff_h - RW'(1)) ||
                       (col_ff == '0) || (WW'(col_ff) == eff_w - WW'(1));

   assign s1_n     = {1'b0, s1_filt_ff} + {1'b0, s1_border_ff};
   assign pop      = (cnt_ff != 2'd0) && rsp_ready;
   assign out_free = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign adv      = s1_valid_ff && ((s1_n == 2'd0) || out_free);
   assign req_ready = !s1_valid_ff || adv;
   assign accept   = req_valid && req_ready;

   // Configuration writes and position counters.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_we) begin
         case (csr_index)
            emb_pkg::CSR_FRAME_WIDTH: begin
               width_in = csr_wdata[emb_pkg::WIDTH_REG_W-1:0];
            end
            emb_pkg::CSR_FRAME_HEIGHT: begin
               height_in = csr_wdata[emb_pkg::HEIGHT_REG_W-1:0];
            end
            default: begin
            end
         endcase
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (WW'(col_ff) == eff_w - WW'(1)) begin
            col_in = '0;
            if (row_ff == eff_h - RW'(1)) begin
               row_in = '0;
            end else begin
               row_in = row_ff + RW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // Pixel stage.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_px_in     = s1_px_ff;
      s1_row_in    = s1_row_ff;
      s1_col_in    = s1_col_ff;
      s1_filt_in   = s1_filt_ff;
      s1_border_in = s1_border_ff;
      if (accept) begin
         s1_valid_in  = 1'b1;
         s1_px_in     = req_px;
         s1_row_in    = row_ff;
         s1_col_in    = col_ff;
         s1_filt_in   = cur_filt;
         s1_border_in = cur_border;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // Line stores: upper holds the row two above, lower the row just above.
   emb_ram #(
      .WIDTH ($bits(emb_pkg::pixel_type)),
      .DEPTH (MAX_WIDTH)
   ) u_upper_ram (
      .clock   (clock),
      .wr_en   (adv),
      .wr_addr (s1_col_ff),
      .wr_data (mid_px),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (top_px)
   );

   emb_ram #(
      .WIDTH ($bits(emb_pkg::pixel_type)),
      .DEPTH (MAX_WIDTH)
   ) u_lower_ram (
      .clock   (clock),
      .wr_en   (adv),
      .wr_addr (s1_col_ff),
      .wr_data (s1_px_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (mid_px)
   );

   // Window: two column cells plus the column being formed from the stores.
   assign new_col[0] = top_px;
   assign new_col[1] = mid_px;
   assign new_col[2] = s1_px_ff;

   emb_col_cell u_cell1 (
      .clock   (clock),
      .shift   (adv),
      .col_in  (new_col),
      .col_out (cell1_col)
   );

   emb_col_cell u_cell0 (
      .clock   (clock),
      .shift   (adv),
      .col_in  (cell1_col),
      .col_out (cell0_col)
   );

   assign win[0] = cell0_col;
   assign win[1] = cell1_col;
   assign win[2] = new_col;

   emb_filter u_filter (
      .win     (win),
      .pix_out (filt_px)
   );

   // The filtered result belongs to the pixel one up and one to the left.
   always_comb begin
      res_filt.out_row     = s1_row_ff - RW'(1);
      res_filt.out_col     = emb_pkg::OUT_COL_W'(s1_col_ff - CW'(1));
      res_filt.red_out     = filt_px.red;
      res_filt.green_out   = filt_px.green;
      res_filt.blue_out    = filt_px.blue;
      res_filt.last_of_run = !s1_border_ff;

      res_border.out_row     = s1_row_ff;
      res_border.out_col     = emb_pkg::OUT_COL_W'(s1_col_ff);
      res_border.red_out     = s1_px_ff.red;
      res_border.green_out   = s1_px_ff.green;
      res_border.blue_out    = s1_px_ff.blue;
      res_border.last_of_run = 1'b1;
   end

   // Output stage: a load only happens once the previous results are gone or leaving.
   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (adv && (s1_n != 2'd0)) begin
         cnt_in   = s1_n;
         slot0_in = s1_filt_ff ? res_filt : res_border;
         slot1_in = res_border;
      end else if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= emb_pkg::WIDTH_RESET;
         height_ff   <= emb_pkg::HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         cnt_ff      <= 2'd0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_px_ff     <= s1_px_in;
      s1_row_ff    <= s1_row_in;
      s1_col_ff    <= s1_col_in;
      s1_filt_ff   <= s1_filt_in;
      s1_border_ff <= s1_border_in;
      slot0_ff     <= slot0_in;
      slot1_ff     <= slot1_in;
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = slot0_ff;

endmodule

`default_nettype wire
